// ===== sv/mer_pkg.sv =====
// Package for the midpoint ellipse rasteriser core.
// Holds the widths, input kind codes, controller states and the command and status structs.
// Depends on nothing.
`default_nettype none

package mer_pkg;

  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned XW         = COORD_BITS + 1;
  localparam int unsigned YW         = COORD_BITS + 2;
  localparam int unsigned SQW        = 2 * COORD_BITS;
  localparam int unsigned MOPW       = 2 * COORD_BITS + 4;
  localparam int unsigned PW         = 2 * MOPW;
  localparam int unsigned DW         = 48;
  localparam int unsigned OUT_W      = 13;
  localparam int unsigned COLOR_W    = 4;

  localparam logic [COLOR_W-1:0] PEN_RESET = COLOR_W'(15);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_RX,
    S_ST_RY,
    S_ST_DY,
    S_ST_INIT,
    S_RC_TX,
    S_RC_A,
    S_RC_TY,
    S_RC_B,
    S_RC_C,
    S_RC_END,
    S_STEP,
    S_NULL
  } state_e;

  typedef enum logic [2:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_TX_TX,
    MUL_RY2_P,
    MUL_TY_TY,
    MUL_RX2_P,
    MUL_RX2_RY2
  } mul_sel_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD_START,
    ACT_SET_RX2,
    ACT_SET_RY2,
    ACT_INIT_D,
    ACT_ACC_SET,
    ACT_ACC_ADD,
    ACT_ACC_FINAL,
    ACT_STEP_OUT,
    ACT_NULL_OUT
  } act_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    act_e     act;
  } cmd_t;

  typedef struct packed {
    logic drawing;
    logic need_rc;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/mer_ctrl.sv =====
// Controller for the midpoint ellipse rasteriser: sequences start set-up, region change
// and result beats. Depends on mer_pkg.
`default_nettype none

module mer_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            kind_i,
  input  wire mer_pkg::status_t stat_i,
  output mer_pkg::cmd_t        cmd_o
);
  import mer_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_START) begin
            state_d = S_ST_RX;
          end else if (!stat_i.drawing) begin
            state_d = S_NULL;
          end else if (stat_i.need_rc) begin
            state_d = S_RC_TX;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_ST_RX:   state_d = S_ST_RY;
      S_ST_RY:   state_d = S_ST_DY;
      S_ST_DY:   state_d = S_ST_INIT;
      S_ST_INIT: state_d = S_NULL;
      S_RC_TX:   state_d = S_RC_A;
      S_RC_A:    state_d = S_RC_TY;
      S_RC_TY:   state_d = S_RC_B;
      S_RC_B:    state_d = S_RC_C;
      S_RC_C:    state_d = S_RC_END;
      S_RC_END:  state_d = S_STEP;
      S_STEP: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_NULL: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.mul_sel = MUL_RX_RX;
    cmd_o.act     = ACT_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && kind_i == KIND_START) begin
          cmd_o.act = ACT_LOAD_START;
        end
      end
      S_ST_RX: cmd_o.mul_sel = MUL_RX_RX;
      S_ST_RY: begin
        cmd_o.mul_sel = MUL_RY_RY;
        cmd_o.act     = ACT_SET_RX2;
      end
      S_ST_DY: begin
        cmd_o.mul_sel = MUL_RX2_RY;
        cmd_o.act     = ACT_SET_RY2;
      end
      S_ST_INIT: cmd_o.act = ACT_INIT_D;
      S_RC_TX:   cmd_o.mul_sel = MUL_TX_TX;
      S_RC_A:    cmd_o.mul_sel = MUL_RY2_P;
      S_RC_TY: begin
        cmd_o.mul_sel = MUL_TY_TY;
        cmd_o.act     = ACT_ACC_SET;
      end
      S_RC_B:    cmd_o.mul_sel = MUL_RX2_P;
      S_RC_C: begin
        cmd_o.mul_sel = MUL_RX2_RY2;
        cmd_o.act     = ACT_ACC_ADD;
      end
      S_RC_END:  cmd_o.act = ACT_ACC_FINAL;
      S_STEP: begin
        if (stat_i.out_free) begin
          cmd_o.act = ACT_STEP_OUT;
        end
      end
      S_NULL: begin
        if (stat_i.out_free) begin
          cmd_o.act = ACT_NULL_OUT;
        end
      end
      default: cmd_o.act = ACT_NONE;
    endcase
  end

  a_rc_ends_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RC_END |=> state_q == S_STEP)
    else $error("region change did not lead to a step");

  a_start_reaches_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.act == ACT_LOAD_START |=> ##4 state_q == S_NULL)
    else $error("start set-up length wrong");

  a_step_needs_drawing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP || state_q == S_RC_TX) |-> stat_i.drawing)
    else $error("step work while idle");

endmodule

`default_nettype wire

// ===== sv/mer_datapath.sv =====
// Datapath for the midpoint ellipse rasteriser: shared multiplier, decision terms,
// offsets, pen colour and the output register. Depends on mer_pkg.
`default_nettype none

module mer_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mer_pkg::cmd_t                 cmd_i,
  output mer_pkg::status_t                   stat_o,
  input  wire logic [mer_pkg::COORD_BITS-1:0] center_x_i,
  input  wire logic [mer_pkg::COORD_BITS-1:0] center_y_i,
  input  wire logic [mer_pkg::COORD_BITS-1:0] radius_x_i,
  input  wire logic [mer_pkg::COORD_BITS-1:0] radius_y_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mer_pkg::COLOR_W-1:0]   cfg_wdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               point_valid_o,
  output logic signed [mer_pkg::OUT_W-1:0]   right_x_o,
  output logic signed [mer_pkg::OUT_W-1:0]   left_x_o,
  output logic signed [mer_pkg::OUT_W-1:0]   lower_y_o,
  output logic signed [mer_pkg::OUT_W-1:0]   upper_y_o,
  output logic [mer_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic                               last_point_o
);
  import mer_pkg::*;

  logic                  drawing_q, second_q, out_valid_q;
  logic [COLOR_W-1:0]    pen_q;
  logic [COORD_BITS-1:0] ccol_q, crow_q, rx_q, ry_q;
  logic [XW-1:0]         ox_q, ox_u;
  logic [YW-1:0]         oy_q, oy_u;
  logic [SQW-1:0]        rx2_q, ry2_q;
  logic [DW-1:0]         dx_q, dy_q, dec_q;
  logic [DW-1:0]         dx_u, dy_u, dec_u, dx_n, dy_n;
  logic [DW-1:0]         rx2_w, ry2_w, prod_w;
  logic [PW-1:0]         prod_q;
  logic [MOPW-1:0]       mul_a, mul_b;
  logic [XW:0]           tx;
  logic [YW-1:0]         ty, ty_mag;
  logic                  out_point_q, out_last_q;
  logic [OUT_W-1:0]      right_q, left_q, lower_q, upper_q;
  logic [COLOR_W-1:0]    color_q;
  logic                  out_load;

  assign rx2_w  = DW'(rx2_q);
  assign ry2_w  = DW'(ry2_q);
  assign prod_w = DW'(prod_q);
  assign tx     = {ox_q, 1'b1};
  assign ty     = oy_q - YW'(1);
  assign ty_mag = ty[YW-1] ? (~ty + YW'(1)) : ty;

  always_comb begin
    mul_a = MOPW'(rx_q);
    mul_b = MOPW'(rx_q);
    case (cmd_i.mul_sel)
      MUL_RX_RX: begin
        mul_a = MOPW'(rx_q);
        mul_b = MOPW'(rx_q);
      end
      MUL_RY_RY: begin
        mul_a = MOPW'(ry_q);
        mul_b = MOPW'(ry_q);
      end
      MUL_RX2_RY: begin
        mul_a = MOPW'(rx2_q);
        mul_b = MOPW'(ry_q);
      end
      MUL_TX_TX: begin
        mul_a = MOPW'(tx);
        mul_b = MOPW'(tx);
      end
      MUL_RY2_P: begin
        mul_a = MOPW'(ry2_q);
        mul_b = prod_q[MOPW-1:0];
      end
      MUL_TY_TY: begin
        mul_a = MOPW'(ty_mag);
        mul_b = MOPW'(ty_mag);
      end
      MUL_RX2_P: begin
        mul_a = MOPW'(rx2_q);
        mul_b = prod_q[MOPW-1:0];
      end
      MUL_RX2_RY2: begin
        mul_a = MOPW'(rx2_q);
        mul_b = MOPW'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // one plotting step, region 1 or region 2
  assign dx_n = dx_q + (ry2_w << 1);
  assign dy_n = dy_q - (rx2_w << 1);

  always_comb begin
    ox_u  = ox_q;
    oy_u  = oy_q;
    dx_u  = dx_q;
    dy_u  = dy_q;
    dec_u = dec_q;
    if (!second_q) begin
      ox_u = ox_q + XW'(1);
      dx_u = dx_n;
      if (dec_q[DW-1]) begin
        dec_u = dec_q + (dx_n << 2) + (ry2_w << 2);
      end else begin
        oy_u  = oy_q - YW'(1);
        dy_u  = dy_n;
        dec_u = dec_q + (dx_n << 2) - (dy_n << 2) + (ry2_w << 2);
      end
    end else begin
      oy_u = oy_q - YW'(1);
      dy_u = dy_n;
      if (!dec_q[DW-1] && dec_q != '0) begin
        dec_u = dec_q + (rx2_w << 2) - (dy_n << 2);
      end else begin
        ox_u  = ox_q + XW'(1);
        dx_u  = dx_n;
        dec_u = dec_q + (dx_n << 2) - (dy_n << 2) + (rx2_w << 2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drawing_q <= 1'b0;
      second_q  <= 1'b0;
      pen_q     <= PEN_RESET;
    end else begin
      if (cfg_we_i) begin
        pen_q <= cfg_wdata_i;
      end
      case (cmd_i.act)
        ACT_LOAD_START: begin
          drawing_q <= 1'b1;
          second_q  <= 1'b0;
        end
        ACT_ACC_FINAL: second_q <= 1'b1;
        ACT_STEP_OUT: begin
          if (oy_u[YW-1]) begin
            drawing_q <= 1'b0;
            second_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      ACT_LOAD_START: begin
        ccol_q <= center_x_i;
        crow_q <= center_y_i;
        rx_q   <= radius_x_i;
        ry_q   <= radius_y_i;
        ox_q   <= '0;
        oy_q   <= YW'(radius_y_i);
        dx_q   <= '0;
      end
      ACT_SET_RX2: rx2_q <= prod_q[SQW-1:0];
      ACT_SET_RY2: ry2_q <= prod_q[SQW-1:0];
      ACT_INIT_D: begin
        dy_q  <= prod_w << 1;
        dec_q <= (ry2_w << 2) - (prod_w << 2) + rx2_w;
      end
      ACT_ACC_SET:   dec_q <= prod_w;
      ACT_ACC_ADD:   dec_q <= dec_q + (prod_w << 2);
      ACT_ACC_FINAL: dec_q <= dec_q - (prod_w << 2);
      ACT_STEP_OUT: begin
        ox_q  <= ox_u;
        oy_q  <= oy_u;
        dx_q  <= dx_u;
        dy_q  <= dy_u;
        dec_q <= dec_u;
      end
      default: ;
    endcase
  end

  // output register
  assign out_load = (cmd_i.act == ACT_STEP_OUT) || (cmd_i.act == ACT_NULL_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_STEP_OUT) begin
      out_point_q <= 1'b1;
      right_q     <= OUT_W'(ccol_q) + OUT_W'(ox_q);
      left_q      <= OUT_W'(ccol_q) - OUT_W'(ox_q);
      lower_q     <= OUT_W'(crow_q) + OUT_W'($signed(oy_q));
      upper_q     <= OUT_W'(crow_q) - OUT_W'($signed(oy_q));
      color_q     <= pen_q;
      out_last_q  <= oy_u[YW-1];
    end else if (cmd_i.act == ACT_NULL_OUT) begin
      out_point_q <= 1'b0;
      right_q     <= '0;
      left_q      <= '0;
      lower_q     <= '0;
      upper_q     <= '0;
      color_q     <= '0;
      out_last_q  <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_valid_o = out_point_q;
  assign right_x_o     = $signed(right_q);
  assign left_x_o      = $signed(left_q);
  assign lower_y_o     = $signed(lower_q);
  assign upper_y_o     = $signed(upper_q);
  assign pixel_color_o = color_q;
  assign last_point_o  = out_last_q;

  assign stat_o.drawing  = drawing_q;
  assign stat_o.need_rc  = !second_q && !($signed(dx_q) < $signed(dy_q));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before its beat");

  a_last_ends_drawing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == ACT_STEP_OUT |=> (out_last_q == !drawing_q))
    else $error("last point and drawing state disagree");

  a_second_only_drawing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> drawing_q)
    else $error("region 2 flag set while idle");

  a_null_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_point_q) |-> (right_q == '0 && color_q == '0 && !out_last_q))
    else $error("empty result carries data");

endmodule

`default_nettype wire

// ===== sv/midpoint_ellipse_rasterizer_core.sv =====
// Top level of the midpoint ellipse rasteriser: joins controller and datapath.
// Depends on mer_pkg, mer_ctrl and mer_datapath.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | kind, center_x/y, radius_x/y
//   out     | output    | out_valid_o / out_ready_i | point_valid, x/y pairs, colour, last
//   cfg     | input     | cfg_we_i                  | cfg_wdata_i (pen colour)
//
// A step beat passes through S_STEP; the step that enters region 2 first runs S_RC_TX to S_RC_END,
// as the region-2 decision term needs five products from the one shared multiplier.
// A start beat runs three squarings/products on the multiplier, then the set-up, then the result.
// Reset leaves the block idle with pen colour 15; no clearing pass.
// A new beat is taken while the previous result still waits; a held result stalls only
// the delivery of the next one.
`default_nettype none

module midpoint_ellipse_rasterizer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [mer_pkg::COORD_BITS-1:0] center_x_i,
  input  wire logic [mer_pkg::COORD_BITS-1:0] center_y_i,
  input  wire logic [mer_pkg::COORD_BITS-1:0] radius_x_i,
  input  wire logic [mer_pkg::COORD_BITS-1:0] radius_y_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mer_pkg::COLOR_W-1:0]   cfg_wdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               point_valid_o,
  output logic signed [mer_pkg::OUT_W-1:0]   right_x_o,
  output logic signed [mer_pkg::OUT_W-1:0]   left_x_o,
  output logic signed [mer_pkg::OUT_W-1:0]   lower_y_o,
  output logic signed [mer_pkg::OUT_W-1:0]   upper_y_o,
  output logic [mer_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic                               last_point_o
);
  import mer_pkg::*;

  cmd_t    cmd;
  status_t stat;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mer_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_x_i    (radius_x_i),
    .radius_y_i    (radius_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_valid_o (point_valid_o),
    .right_x_o     (right_x_o),
    .left_x_o      (left_x_o),
    .lower_y_o     (lower_y_o),
    .upper_y_o     (upper_y_o),
    .pixel_color_o (pixel_color_o),
    .last_point_o  (last_point_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for midpoint_ellipse_rasterizer_core.
// Runs a directed table, then random ellipse traces, mostly under random back-pressure,
// and checks each beat against the table or a predictor. Depends on mer_pkg and the core.
`default_nettype none

module tb;
  import mer_pkg::*;

  typedef struct packed {
    logic               point_valid;
    logic [OUT_W-1:0]   right_x;
    logic [OUT_W-1:0]   left_x;
    logic [OUT_W-1:0]   lower_y;
    logic [OUT_W-1:0]   upper_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_point;
  } plot_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic                  typed;
    plot_t                 want;
  } stim_row_t;

  localparam plot_t NO_POINT    = '0;
  localparam plot_t ORIGIN_LAST = '{1'b1, 13'd0, 13'd0, 13'd0, 13'd0, 4'd15, 1'b1};
  localparam logic [COORD_BITS-1:0] ALL = '1;
  localparam int N_DIR = 25;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = KIND_START;
  logic [COORD_BITS-1:0] center_x_i = '0;
  logic [COORD_BITS-1:0] center_y_i = '0;
  logic [COORD_BITS-1:0] radius_x_i = '0;
  logic [COORD_BITS-1:0] radius_y_i = '0;
  logic cfg_we_i = 1'b0;
  logic [COLOR_W-1:0] cfg_wdata_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic point_valid_o;
  logic signed [OUT_W-1:0] right_x_o, left_x_o, lower_y_o, upper_y_o;
  logic [COLOR_W-1:0] pixel_color_o;
  logic last_point_o;

  // predictor state
  bit                  tracing = 1'b0;
  bit                  in_region_two = 1'b0;
  bit [COORD_BITS-1:0] ctr_col = '0;
  bit [COORD_BITS-1:0] ctr_row = '0;
  bit [XW-1:0]         x_off = '0;
  int                  y_off = 0;
  bit [63:0]           rx_sq = '0;
  bit [63:0]           ry_sq = '0;
  bit [DW-1:0]         grad_x = '0;
  bit [DW-1:0]         grad_y = '0;
  bit [DW-1:0]         mid_term = '0;
  bit [COLOR_W-1:0]    pen = PEN_RESET;

  plot_t expected_plots[$];
  plot_t oldest_plot;
  int    fails = 0;
  bit    steady = 1'b0;

  stim_row_t directed_rows [N_DIR] = '{
    '{KIND_STEP,  0,    0,    0,    0,    1'b1, NO_POINT},
    '{KIND_START, 0,    0,    0,    0,    1'b1, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b1, ORIGIN_LAST},
    '{KIND_STEP,  0,    0,    0,    0,    1'b1, NO_POINT},
    '{KIND_START, 2047, 0,    3,    2,    1'b1, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT},
    '{KIND_START, 1024, 1024, 20,   30,   1'b1, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT},
    '{KIND_START, 0,    2047, 2047, 2047, 1'b1, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT},
    '{KIND_START, 1024, 512,  5,    0,    1'b1, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_START, 512,  1024, 0,    4,    1'b1, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT},
    '{KIND_STEP,  ALL,  ALL,  ALL,  ALL,  1'b0, NO_POINT},
    '{KIND_STEP,  0,    0,    0,    0,    1'b0, NO_POINT}
  };

  midpoint_ellipse_rasterizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_x_i    (radius_x_i),
    .radius_y_i    (radius_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_valid_o (point_valid_o),
    .right_x_o     (right_x_o),
    .left_x_o      (left_x_o),
    .lower_y_o     (lower_y_o),
    .upper_y_o     (upper_y_o),
    .pixel_color_o (pixel_color_o),
    .last_point_o  (last_point_o)
  );

  always #10 clk_i = ~clk_i;

  // Decision terms are kept scaled by four, wrapping at 48 bits.
  function automatic plot_t predict_plot(input logic kind,
                                         input logic [COORD_BITS-1:0] cx, cy, rx, ry);
    plot_t     p;
    bit [63:0] tx, ty, xo, yo;
    p = '0;
    if (kind == KIND_START) begin
      ctr_col       = cx;
      ctr_row       = cy;
      rx_sq         = 64'(rx) * 64'(rx);
      ry_sq         = 64'(ry) * 64'(ry);
      x_off         = '0;
      y_off         = int'(ry);
      grad_x        = '0;
      grad_y        = DW'(64'd2 * rx_sq * 64'(ry));
      mid_term      = DW'(64'd4 * ry_sq - 64'd4 * rx_sq * 64'(ry) + rx_sq);
      tracing       = 1'b1;
      in_region_two = 1'b0;
      return p;
    end
    if (!tracing) return p;

    if (!in_region_two && !($signed(grad_x) < $signed(grad_y))) begin
      tx = 64'd2 * 64'(x_off) + 64'd1;
      ty = longint'(y_off) - 64'sd1;
      in_region_two = 1'b1;
      mid_term = DW'(ry_sq * tx * tx + 64'd4 * rx_sq * ty * ty - 64'd4 * rx_sq * ry_sq);
    end

    xo = 64'(x_off);
    yo = longint'(y_off);
    p.point_valid = 1'b1;
    p.right_x     = OUT_W'(64'(ctr_col) + xo);
    p.left_x      = OUT_W'(64'(ctr_col) - xo);
    p.lower_y     = OUT_W'(64'(ctr_row) + yo);
    p.upper_y     = OUT_W'(64'(ctr_row) - yo);
    p.pixel_color = pen;

    if (!in_region_two) begin
      x_off  = x_off + 1'b1;
      grad_x = DW'(64'(grad_x) + 64'd2 * ry_sq);
      if (mid_term[DW-1]) begin
        mid_term = DW'(64'(mid_term) + 64'd4 * 64'(grad_x) + 64'd4 * ry_sq);
      end else begin
        y_off    = y_off - 1;
        grad_y   = DW'(64'(grad_y) - 64'd2 * rx_sq);
        mid_term = DW'(64'(mid_term) + 64'd4 * 64'(grad_x) - 64'd4 * 64'(grad_y)
                       + 64'd4 * ry_sq);
      end
    end else begin
      y_off  = y_off - 1;
      grad_y = DW'(64'(grad_y) - 64'd2 * rx_sq);
      if (!mid_term[DW-1] && mid_term != '0) begin
        mid_term = DW'(64'(mid_term) + 64'd4 * rx_sq - 64'd4 * 64'(grad_y));
      end else begin
        x_off    = x_off + 1'b1;
        grad_x   = DW'(64'(grad_x) + 64'd2 * ry_sq);
        mid_term = DW'(64'(mid_term) + 64'd4 * 64'(grad_x) - 64'd4 * 64'(grad_y)
                       + 64'd4 * rx_sq);
      end
    end

    if (y_off < 0) begin
      p.last_point  = 1'b1;
      tracing       = 1'b0;
      in_region_two = 1'b0;
    end
    return p;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom);
  endfunction

  task automatic send_item(input logic kind, input logic [COORD_BITS-1:0] cx, cy, rx, ry,
                           input logic typed, input plot_t want);
    plot_t p;
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_x_i <= rx;
    radius_y_i <= ry;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    p = predict_plot(kind, cx, cy, rx, ry);
    expected_plots.push_back(typed ? want : p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_plots.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pen(input logic [COLOR_W-1:0] colour);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= colour;
    pen = colour;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly whole ellipses with random radii, some cut short, plus stray beats.
  task automatic run_random(input int unsigned quota);
    int unsigned sent, pick, size, cap, n;
    logic [COORD_BITS-1:0] rx, ry;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        size = $urandom_range(0, 99);
        if (size < 80) begin
          rx = COORD_BITS'($urandom_range(0, 12));
          ry = COORD_BITS'($urandom_range(0, 12));
        end else if (size < 95) begin
          rx = COORD_BITS'($urandom_range(0, 60));
          ry = COORD_BITS'($urandom_range(0, 60));
        end else begin
          rx = rand_coord();
          ry = rand_coord();
        end
        send_item(KIND_START, rand_coord(), rand_coord(), rx, ry, 1'b0, NO_POINT);
        sent++;
        cap = (pick < 10) ? $urandom_range(0, 5) : 70;
        n = 0;
        while (n < cap && tracing) begin
          send_item(KIND_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    1'b0, NO_POINT);
          n++;
          sent++;
        end
      end else begin
        send_item(($urandom_range(0, 3) != 0) ? KIND_STEP : KIND_START, rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), 1'b0, NO_POINT);
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_plots.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        oldest_plot = expected_plots.pop_front();
        check_field("point_valid", OUT_W'(oldest_plot.point_valid), OUT_W'(point_valid_o));
        check_field("right_x", oldest_plot.right_x, right_x_o);
        check_field("left_x", oldest_plot.left_x, left_x_o);
        check_field("lower_y", oldest_plot.lower_y, lower_y_o);
        check_field("upper_y", oldest_plot.upper_y, upper_y_o);
        check_field("pixel_color", OUT_W'(oldest_plot.pixel_color), OUT_W'(pixel_color_o));
        check_field("last_point", OUT_W'(oldest_plot.last_point), OUT_W'(last_point_o));
      end
    end
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      send_item(directed_rows[i].kind, directed_rows[i].cx, directed_rows[i].cy,
                directed_rows[i].rx, directed_rows[i].ry, directed_rows[i].typed,
                directed_rows[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      if (phase == 0) write_pen('0);
      else if (phase == 1) write_pen('1);
      else write_pen(COLOR_W'($urandom_range(1, 14)));
      steady = (phase == 1);
      run_random(112);
    end

    drain();
    steady = 1'b0;
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
